/* hw/rtl/tdaft_pkg.sv */
// Shared constants and types for the tick housekeeping timer block.
`timescale 1ns / 1ps

package tdaft_pkg;

	localparam int unsigned DebWidth   = 4;
	localparam int unsigned ScanWidth  = 10;
	localparam int unsigned A1Width    = 8;
	localparam int unsigned A2Width    = 8;
	localparam int unsigned FanWidth   = 12;
	localparam int unsigned CfgWidth   = 12;
	localparam int unsigned IndexWidth = 2;

	typedef enum logic [IndexWidth-1:0] {
		REG_DEBOUNCE_TICKS     = 2'd0,
		REG_SCAN_PERIOD        = 2'd1,
		REG_ALARM1_HALF_PERIOD = 2'd2,
		REG_FAN_OFF_DELAY      = 2'd3
	} reg_index_t;

	localparam logic [DebWidth-1:0]  DebounceReset = 4'd5;
	localparam logic [ScanWidth-1:0] ScanReset     = 10'd100;
	localparam logic [A1Width-1:0]   A1Reset       = 8'd50;
	localparam logic [FanWidth-1:0]  FanReset      = 12'd1500;

	// Alarm two cadence: count runs 1..199, buzzer sounds in three windows.
	localparam logic [A2Width-1:0] A2Wrap     = 8'd200;
	localparam logic [A2Width-1:0] A2Win1Low  = 8'd20;
	localparam logic [A2Width-1:0] A2Win1High = 8'd39;
	localparam logic [A2Width-1:0] A2Win2Low  = 8'd60;
	localparam logic [A2Width-1:0] A2Win2High = 8'd79;
	localparam logic [A2Width-1:0] A2Win3Low  = 8'd100;
	localparam logic [A2Width-1:0] A2Win3High = 8'd119;

	typedef struct packed {
		logic fan_on_request;
		logic fan_delay_start;
		logic alarm2_active;
		logic alarm1_active;
		logic scan_clear;
		logic signal_level;
	} tick_in_t;

	typedef struct packed {
		logic fan_delay_pending;
		logic fan_running;
		logic buzzer_drive;
		logic scan_request;
		logic signal_state;
	} tick_out_t;

endpackage

/* hw/rtl/tick_debounce_alarm_fan_timer_unit.sv */
// Top level of the tick housekeeping timer: debounce, scan, buzzer and fan delay.
// The result of an accepted request is written into the output register at the accepting edge.
// Throughput: one request per cycle while the receiver is ready; the output register refills in the cycle it is taken.
// All counters update in a single pass of next-state logic at the accepting edge.
// Reset (arst_n low) clears all counters and flags, sets the beep phase to one and
// loads the configuration registers with their reset values.
`timescale 1ns / 1ps

module tick_debounce_alarm_fan_timer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tdaft_pkg::IndexWidth-1:0]  cfg_index,
	input  logic [tdaft_pkg::CfgWidth-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [0] signal_level, [1] scan_clear, [2] alarm1_active, [3] alarm2_active,
	// [4] fan_delay_start, [5] fan_on_request, [7:6] zero
	input  logic [7:0]                        s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] signal_state, [1] scan_request, [2] buzzer_drive, [3] fan_running,
	// [4] fan_delay_pending, [7:5] zero
	output logic [7:0]                        m_axis_tdata
);

	import tdaft_pkg::*;

	logic [DebWidth-1:0]  debounce_ticks_q;
	logic [ScanWidth-1:0] scan_period_q;
	logic [A1Width-1:0]   alarm1_half_period_q;
	logic [FanWidth-1:0]  fan_off_delay_q;

	logic [DebWidth-1:0]  low_run_q, high_run_q;
	logic                 deb_flag_q;
	logic [ScanWidth-1:0] scan_count_q;
	logic                 scan_flag_q;
	logic [A1Width-1:0]   a1_count_q;
	logic                 beep_phase_q;
	logic [A2Width-1:0]   a2_count_q;
	logic                 buzzer_q;
	logic                 fan_delay_q;
	logic                 fan_en_q;
	logic [FanWidth-1:0]  fan_count_q;

	logic [DebWidth-1:0]  low_run_d, high_run_d;
	logic                 deb_flag_d;
	logic [ScanWidth-1:0] scan_count_d;
	logic                 scan_flag_d;
	logic [A1Width-1:0]   a1_count_d;
	logic                 beep_phase_d;
	logic [A2Width-1:0]   a2_count_d;
	logic                 buzzer_d;
	logic                 fan_delay_d;
	logic                 fan_en_d;
	logic [FanWidth-1:0]  fan_count_d;

	logic [DebWidth:0]    low_inc, high_inc;
	logic [ScanWidth:0]   scan_inc;
	logic [A1Width:0]     a1_inc;
	logic [A2Width:0]     a2_inc;
	logic [FanWidth:0]    fan_inc;

	tick_in_t  req;
	tick_out_t res_d;
	tick_out_t res_q;
	logic      out_valid_q;
	logic      accept;

	assign req           = tick_in_t'(s_axis_tdata[5:0]);
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q};

	assign low_inc  = {1'b0, low_run_q} + 1'b1;
	assign high_inc = {1'b0, high_run_q} + 1'b1;
	assign scan_inc = {1'b0, scan_count_q} + 1'b1;
	assign a1_inc   = {1'b0, a1_count_q} + 1'b1;
	assign a2_inc   = {1'b0, a2_count_q} + 1'b1;
	assign fan_inc  = {1'b0, fan_count_q} + 1'b1;

	always_comb begin
		low_run_d    = low_run_q;
		high_run_d   = high_run_q;
		deb_flag_d   = deb_flag_q;
		scan_count_d = scan_count_q;
		scan_flag_d  = scan_flag_q && !req.scan_clear;
		a1_count_d   = a1_count_q;
		beep_phase_d = beep_phase_q;
		a2_count_d   = a2_count_q;
		buzzer_d     = buzzer_q;
		fan_delay_d  = fan_delay_q || req.fan_delay_start;
		fan_en_d     = fan_en_q || req.fan_on_request;
		fan_count_d  = fan_count_q;

		if (!req.signal_level) begin
			high_run_d = '0;
			if (low_inc >= {1'b0, debounce_ticks_q}) begin
				low_run_d  = '0;
				deb_flag_d = 1'b1;
			end else begin
				low_run_d = low_inc[DebWidth-1:0];
			end
		end else begin
			low_run_d = '0;
			if (high_inc >= {1'b0, debounce_ticks_q}) begin
				high_run_d = '0;
				deb_flag_d = 1'b0;
			end else begin
				high_run_d = high_inc[DebWidth-1:0];
			end
		end

		// The count holds while a scan request is outstanding.
		if (!scan_flag_d) begin
			if (scan_inc >= {1'b0, scan_period_q}) begin
				scan_count_d = '0;
				scan_flag_d  = 1'b1;
			end else begin
				scan_count_d = scan_inc[ScanWidth-1:0];
			end
		end

		// The buzzer sounds when the phase after the toggle is zero.
		if (req.alarm1_active) begin
			if (a1_inc >= {1'b0, alarm1_half_period_q}) begin
				a1_count_d   = '0;
				beep_phase_d = !beep_phase_q;
				buzzer_d     = beep_phase_q;
			end else begin
				a1_count_d = a1_inc[A1Width-1:0];
			end
		end

		// Alarm two is evaluated last, so it overrides alarm one.
		if (req.alarm2_active) begin
			if (a2_inc >= {1'b0, A2Wrap}) begin
				a2_count_d = A2Width'(1);
			end else begin
				a2_count_d = a2_inc[A2Width-1:0];
			end
			buzzer_d = (a2_count_d >= A2Win1Low && a2_count_d <= A2Win1High) ||
				(a2_count_d >= A2Win2Low && a2_count_d <= A2Win2High) ||
				(a2_count_d >= A2Win3Low && a2_count_d <= A2Win3High);
		end

		if (fan_delay_d) begin
			if (fan_inc >= {1'b0, fan_off_delay_q}) begin
				fan_count_d = '0;
				fan_en_d    = 1'b0;
				fan_delay_d = 1'b0;
			end else begin
				fan_count_d = fan_inc[FanWidth-1:0];
			end
		end else begin
			fan_count_d = '0;
		end

		res_d.signal_state      = deb_flag_d;
		res_d.scan_request      = scan_flag_d;
		res_d.buzzer_drive      = buzzer_d;
		res_d.fan_running       = fan_en_d;
		res_d.fan_delay_pending = fan_delay_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q     <= DebounceReset;
			scan_period_q        <= ScanReset;
			alarm1_half_period_q <= A1Reset;
			fan_off_delay_q      <= FanReset;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_DEBOUNCE_TICKS:     debounce_ticks_q     <= cfg_data[DebWidth-1:0];
				REG_SCAN_PERIOD:        scan_period_q        <= cfg_data[ScanWidth-1:0];
				REG_ALARM1_HALF_PERIOD: alarm1_half_period_q <= cfg_data[A1Width-1:0];
				REG_FAN_OFF_DELAY:      fan_off_delay_q      <= cfg_data[FanWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_run_q    <= '0;
			high_run_q   <= '0;
			deb_flag_q   <= 1'b0;
			scan_count_q <= '0;
			scan_flag_q  <= 1'b0;
			a1_count_q   <= '0;
			beep_phase_q <= 1'b1;
			a2_count_q   <= '0;
			buzzer_q     <= 1'b0;
			fan_delay_q  <= 1'b0;
			fan_en_q     <= 1'b0;
			fan_count_q  <= '0;
		end else if (accept) begin
			low_run_q    <= low_run_d;
			high_run_q   <= high_run_d;
			deb_flag_q   <= deb_flag_d;
			scan_count_q <= scan_count_d;
			scan_flag_q  <= scan_flag_d;
			a1_count_q   <= a1_count_d;
			beep_phase_q <= beep_phase_d;
			a2_count_q   <= a2_count_d;
			buzzer_q     <= buzzer_d;
			fan_delay_q  <= fan_delay_d;
			fan_en_q     <= fan_en_d;
			fan_count_q  <= fan_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

endmodule

/* tb/tick_debounce_alarm_fan_timer_unit_tb.sv */
// Self-checking testbench for the tick housekeeping timer with a cycle-free tick predictor.
`timescale 1ns / 1ps

module tick_debounce_alarm_fan_timer_unit_tb;
	import tdaft_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IndexWidth-1:0] cfg_index = '0;
	logic [CfgWidth-1:0]   cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;

	tick_debounce_alarm_fan_timer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the settings and the counters.
	logic [DebWidth-1:0]  cfg_debounce;
	logic [ScanWidth-1:0] cfg_scan;
	logic [A1Width-1:0]   cfg_a1;
	logic [FanWidth-1:0]  cfg_fan;
	logic [DebWidth-1:0]  lo_run, hi_run;
	logic                 level_flag;
	logic [ScanWidth-1:0] scan_ticks;
	logic                 scan_due;
	logic [A1Width-1:0]   a1_ticks;
	logic                 a1_phase;
	logic [A2Width-1:0]   a2_ticks;
	logic                 buzz;
	logic                 fan_armed, fan_en;
	logic [FanWidth-1:0]  fan_ticks;

	tick_in_t  tick_q[$];
	tick_out_t status_q[$];
	int        results_seen = 0;
	int        mismatches = 0;
	bit        idle_on = 1'b0;
	bit        run_live = 1'b0;

	// Sticky state for the shaped random ticks.
	bit cur_level = 1'b1;
	int level_run = 0;
	bit a1_on = 1'b0;
	bit a2_on = 1'b0;

	function automatic bit in_alarm2_window(logic [A2Width-1:0] c);
		return (c >= A2Win1Low && c <= A2Win1High) || (c >= A2Win2Low && c <= A2Win2High) ||
			(c >= A2Win3Low && c <= A2Win3High);
	endfunction

	function tick_out_t advance_tick(tick_in_t t);
		tick_out_t o;
		if (t.scan_clear) scan_due = 1'b0;
		if (t.fan_delay_start) fan_armed = 1'b1;
		if (t.fan_on_request) fan_en = 1'b1;

		if (!t.signal_level) begin
			lo_run = lo_run + 1'b1;
			hi_run = '0;
			if (lo_run >= cfg_debounce) begin
				lo_run = '0;
				level_flag = 1'b1;
			end
		end else begin
			hi_run = hi_run + 1'b1;
			lo_run = '0;
			if (hi_run >= cfg_debounce) begin
				hi_run = '0;
				level_flag = 1'b0;
			end
		end

		if (!scan_due) begin
			scan_ticks = scan_ticks + 1'b1;
			if (scan_ticks >= cfg_scan) begin
				scan_ticks = '0;
				scan_due = 1'b1;
			end
		end

		if (t.alarm1_active) begin
			a1_ticks = a1_ticks + 1'b1;
			if (a1_ticks >= cfg_a1) begin
				a1_ticks = '0;
				a1_phase = ~a1_phase;
				buzz = ~a1_phase;
			end
		end

		// Alarm two comes last, so it wins over alarm one.
		if (t.alarm2_active) begin
			a2_ticks = a2_ticks + 1'b1;
			if (a2_ticks >= A2Wrap) a2_ticks = 8'd1;
			buzz = in_alarm2_window(a2_ticks);
		end

		if (fan_armed) begin
			fan_ticks = fan_ticks + 1'b1;
			if (fan_ticks >= cfg_fan) begin
				fan_ticks = '0;
				fan_en = 1'b0;
				fan_armed = 1'b0;
			end
		end else begin
			fan_ticks = '0;
		end

		o.signal_state = level_flag;
		o.scan_request = scan_due;
		o.buzzer_drive = buzz;
		o.fan_running = fan_en;
		o.fan_delay_pending = fan_armed;
		return o;
	endfunction

	function automatic tick_in_t mk(bit level, bit clr, bit a1, bit a2, bit dly, bit on);
		tick_in_t t;
		t.signal_level = level;
		t.scan_clear = clr;
		t.alarm1_active = a1;
		t.alarm2_active = a2;
		t.fan_delay_start = dly;
		t.fan_on_request = on;
		return t;
	endfunction

	// Mostly held levels and alarm runs so that the counters reach their thresholds;
	// one tick in ten is plain noise.
	function tick_in_t random_tick();
		tick_in_t t;
		if ($urandom_range(0, 9) == 0) return tick_in_t'(6'($urandom_range(0, 63)));
		if (level_run == 0) begin
			cur_level = ~cur_level;
			level_run = $urandom_range(1, 20);
		end
		level_run--;
		if ($urandom_range(0, 29) == 0) a1_on = ~a1_on;
		if ($urandom_range(0, 49) == 0) a2_on = ~a2_on;
		t = mk(cur_level, $urandom_range(0, 7) == 0, a1_on, a2_on,
			$urandom_range(0, 29) == 0, $urandom_range(0, 19) == 0);
		return t;
	endfunction

	task automatic write_setting(reg_index_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CfgWidth-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEBOUNCE_TICKS:     cfg_debounce = val[DebWidth-1:0];
			REG_SCAN_PERIOD:        cfg_scan = val[ScanWidth-1:0];
			REG_ALARM1_HALF_PERIOD: cfg_a1 = val[A1Width-1:0];
			REG_FAN_OFF_DELAY:      cfg_fan = val[FanWidth-1:0];
		endcase
	endtask

	task automatic write_all(int unsigned deb, int unsigned scan, int unsigned a1,
			int unsigned fan);
		write_setting(REG_DEBOUNCE_TICKS, deb);
		write_setting(REG_SCAN_PERIOD, scan);
		write_setting(REG_ALARM1_HALF_PERIOD, a1);
		write_setting(REG_FAN_OFF_DELAY, fan);
	endtask

	// Wait until every queued request has gone in and every status has come back.
	task automatic drain();
		while (tick_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic random_phase(int n, bit with_idle);
		idle_on = with_idle;
		repeat (n) tick_q.push_back(random_tick());
		drain();
	endtask

	// Request driver.
	int gap_left = 0;
	always @(posedge clk) begin
		if (run_live) begin
			if (s_axis_tvalid && s_axis_tready)
				status_q.push_back(advance_tick(tick_in_t'(s_axis_tdata[5:0])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 15);
					s_axis_tvalid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {2'b00, tick_q.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Status monitor and receiver stalls.
	int stall_left = 0;
	always @(posedge clk) begin
		tick_out_t want;
		tick_out_t got;
		string names[5];
		names = '{"signal_state", "scan_request", "buzzer_drive", "fan_running",
			"fan_delay_pending"};
		if (run_live) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = tick_out_t'(m_axis_tdata[4:0]);
				if (status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status %0d arrived with nothing expected: %b",
							results_seen, m_axis_tdata);
				end else begin
					want = status_q.pop_front();
					for (int i = 0; i < 5; i++) begin
						if (got[i] !== want[i]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("status %0d %s: expected %0b, got %0b",
									results_seen, names[i], want[i], got[i]);
						end
					end
					if (m_axis_tdata[7:5] !== 3'b000) begin
						mismatches++;
						if (mismatches <= 10)
							$display("status %0d padding: expected 000, got %b",
								results_seen, m_axis_tdata[7:5]);
					end
				end
				results_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 15);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tick_debounce_alarm_fan_timer_unit_tb: FAIL");
		$finish;
	end

	initial begin
		cfg_debounce = DebounceReset;
		cfg_scan = ScanReset;
		cfg_a1 = A1Reset;
		cfg_fan = FanReset;
		lo_run = '0;
		hi_run = '0;
		level_flag = 1'b0;
		scan_ticks = '0;
		scan_due = 1'b0;
		a1_ticks = '0;
		a1_phase = 1'b1;
		a2_ticks = '0;
		buzz = 1'b0;
		fan_armed = 1'b0;
		fan_en = 1'b0;
		fan_ticks = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_live = 1'b1;

		// Directed: quiet tick, everything set, then each field alone, at reset settings.
		tick_q.push_back(mk(0, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 1, 1, 1, 1, 1));
		tick_q.push_back(mk(1, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(0, 1, 0, 0, 0, 0));
		tick_q.push_back(mk(0, 0, 1, 0, 0, 0));
		tick_q.push_back(mk(0, 0, 0, 1, 0, 0));
		tick_q.push_back(mk(0, 0, 0, 0, 1, 0));
		tick_q.push_back(mk(0, 0, 0, 0, 0, 1));
		drain();

		// Directed with short thresholds: debounce in both directions with a broken run,
		// scan clear, alarm one toggles, alarm two overriding, fan delay re-armed.
		write_all(2, 3, 2, 3);
		tick_q.push_back(mk(0, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(0, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(0, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 1, 0, 0, 0, 0));
		repeat (4) tick_q.push_back(mk(1, 0, 1, 0, 0, 0));
		tick_q.push_back(mk(1, 0, 1, 1, 0, 0));
		tick_q.push_back(mk(1, 0, 0, 0, 1, 1));
		tick_q.push_back(mk(1, 0, 0, 0, 1, 0));
		tick_q.push_back(mk(1, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 0, 0, 0, 0, 0));
		drain();

		// Largest thresholds, then thresholds of one, which land below the running counts.
		write_all(15, 1023, 255, 4095);
		random_phase(250, 1'b1);
		write_all(1, 1, 1, 1);
		random_phase(100, 1'b1);
		write_all($urandom_range(1, 15), $urandom_range(1, 40), $urandom_range(1, 30),
			$urandom_range(1, 60));
		random_phase(100, 1'b0);
		write_all($urandom_range(1, 15), $urandom_range(1, 1023), $urandom_range(1, 255),
			$urandom_range(1, 4095));
		random_phase(100, 1'b1);
		write_all($urandom_range(2, 8), $urandom_range(2, 20), $urandom_range(2, 10),
			$urandom_range(2, 30));
		random_phase(100, 1'b1);
		write_all($urandom_range(1, 15), $urandom_range(1, 100), $urandom_range(1, 50),
			$urandom_range(1, 200));
		random_phase(100, 1'b1);
		random_phase(100, 1'b0);

		repeat (5) @(posedge clk);
		if (mismatches == 0 && status_q.size() == 0) begin
			$display("tick_debounce_alarm_fan_timer_unit_tb: PASS");
		end else begin
			$display("tick_debounce_alarm_fan_timer_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
